// ===== rtl/core/bmmt_pkg.sv =====
package bmmt_pkg;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned REGION_W = 4;
  localparam int unsigned OFFSET_W = 21;
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef enum logic [REGION_W-1:0] {
    REGION_ROM      = 4'd0,
    REGION_VRAM     = 4'd1,
    REGION_CRAM     = 4'd2,
    REGION_WRAM     = 4'd3,
    REGION_OAM      = 4'd4,
    REGION_UNUSABLE = 4'd5,
    REGION_IO       = 4'd6,
    REGION_HRAM     = 4'd7,
    REGION_MBC      = 4'd8
  } bmmt_region_t;

  // bank controller register groups, picked by address bits 14:13
  localparam logic [1:0] MBC_RAM_ENABLE = 2'd0;
  localparam logic [1:0] MBC_ROM_LOW    = 2'd1;
  localparam logic [1:0] MBC_ROM_HIGH   = 2'd2;
  localparam logic [1:0] MBC_MODE       = 2'd3;

  localparam logic [DATA_W-1:0] RAM_EN_MASK = 8'h0A;
  localparam logic [DATA_W-1:0] MODE_SIMPLE = 8'h00;
  localparam logic [DATA_W-1:0] MODE_ADV    = 8'h01;

  localparam logic [ADDR_W-1:0] ADDR_VRAM     = 16'h8000;
  localparam logic [ADDR_W-1:0] ADDR_CRAM     = 16'hA000;
  localparam logic [ADDR_W-1:0] ADDR_WRAM     = 16'hC000;
  localparam logic [ADDR_W-1:0] ADDR_OAM      = 16'hFE00;
  localparam logic [ADDR_W-1:0] ADDR_UNUSABLE = 16'hFEA0;
  localparam logic [ADDR_W-1:0] ADDR_IO       = 16'hFF00;
  localparam logic [ADDR_W-1:0] ADDR_HRAM     = 16'hFF80;

  localparam logic [PADDR_W-1:0] CFG_ADDR_MBC1  = 4'h0;
  localparam logic [PADDR_W-1:0] CFG_ADDR_VBANK = 4'h4;
  localparam logic [PADDR_W-1:0] CFG_ADDR_WBANK = 4'h8;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] bus_address;
    logic [DATA_W-1:0] write_data;
  } bmmt_req_t;

  typedef struct packed {
    logic [REGION_W-1:0] region;
    logic [OFFSET_W-1:0] physical_offset;
    logic                ram_enabled;
  } bmmt_rsp_t;

  typedef struct packed {
    logic       cart_is_mbc1;
    logic       video_bank;
    logic [2:0] work_bank;
  } bmmt_cfg_t;

endpackage

// ===== rtl/core/bmmt_in_if.sv =====
interface bmmt_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] bus_address;
  logic [7:0]  write_data;

  modport source (output valid, kind, bus_address, write_data, input ready);
  modport sink (input valid, kind, bus_address, write_data, output ready);
endinterface

// ===== rtl/core/bmmt_out_if.sv =====
interface bmmt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  region;
  logic [20:0] physical_offset;
  logic        ram_enabled;

  modport source (output valid, region, physical_offset, ram_enabled, input ready);
  modport sink (input valid, region, physical_offset, ram_enabled, output ready);
endinterface

// ===== rtl/core/bmmt_ctrl.sv =====
module bmmt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  bmmt_pkg::bmmt_cfg_t cfg,
  input  bmmt_pkg::bmmt_req_t req,
  output bmmt_pkg::bmmt_rsp_t rsp
);
  import bmmt_pkg::*;

  logic [6:0]          rom_bank_r, rom_bank_nxt;
  logic [1:0]          ram_bank_r, ram_bank_nxt;
  logic                mode_r, mode_nxt;
  logic                ram_en_r, ram_en_nxt;
  logic                mbc_wr;
  logic [4:0]          lo_bits;
  logic [ADDR_W-1:0]   a;
  logic [7:0]          unusable_off;
  bmmt_region_t        region;
  logic [OFFSET_W-1:0] offset;

  assign a            = req.bus_address;
  assign mbc_wr       = cfg.cart_is_mbc1 && (req.kind == KIND_WRITE) && !a[15];
  assign lo_bits      = (req.write_data[4:0] == 5'd0) ? 5'd1 : req.write_data[4:0];
  assign unusable_off = a[7:0] - ADDR_UNUSABLE[7:0];

  // bank controller update
  always_comb begin
    rom_bank_nxt = rom_bank_r;
    ram_bank_nxt = ram_bank_r;
    mode_nxt     = mode_r;
    ram_en_nxt   = ram_en_r;
    if (mbc_wr) begin
      unique case (a[14:13])
        MBC_RAM_ENABLE: begin
          ram_en_nxt = ((req.write_data & RAM_EN_MASK) == RAM_EN_MASK);
        end
        MBC_ROM_LOW: begin
          rom_bank_nxt = {rom_bank_r[6:5], lo_bits};
        end
        MBC_ROM_HIGH: begin
          if (!mode_r) begin
            rom_bank_nxt = {req.write_data[1:0], rom_bank_r[4:0]};
          end else begin
            ram_bank_nxt = req.write_data[1:0];
          end
        end
        MBC_MODE: begin
          if (req.write_data == MODE_SIMPLE) begin
            mode_nxt = 1'b0;
          end else if (req.write_data == MODE_ADV) begin
            mode_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  // address translation
  always_comb begin
    region = REGION_ROM;
    offset = '0;
    if (mbc_wr) begin
      region = REGION_MBC;
      offset = {5'd0, a};
    end else if (!a[15] && !a[14]) begin
      region = REGION_ROM;
      offset = {7'd0, a[13:0]};
    end else if (!a[15]) begin
      region = REGION_ROM;
      offset = {rom_bank_r, a[13:0]};
    end else if (a < ADDR_CRAM) begin
      region = REGION_VRAM;
      offset = {7'd0, cfg.video_bank, a[12:0]};
    end else if (a < ADDR_WRAM) begin
      region = REGION_CRAM;
      offset = {6'd0, ram_bank_r, a[12:0]};
    end else if (a < ADDR_OAM) begin
      region = REGION_WRAM;
      offset = a[12] ? {6'd0, cfg.work_bank, a[11:0]} : {9'd0, a[11:0]};
    end else if (a < ADDR_UNUSABLE) begin
      region = REGION_OAM;
      offset = {13'd0, a[7:0]};
    end else if (a < ADDR_IO) begin
      region = REGION_UNUSABLE;
      offset = {13'd0, unusable_off};
    end else if (a < ADDR_HRAM) begin
      region = REGION_IO;
      offset = {14'd0, a[6:0]};
    end else begin
      region = REGION_HRAM;
      offset = {14'd0, a[6:0]};
    end
  end

  assign rsp.region          = region;
  assign rsp.physical_offset = offset;
  assign rsp.ram_enabled     = ram_en_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_r <= 7'd1;
      ram_bank_r <= 2'd0;
      mode_r     <= 1'b0;
      ram_en_r   <= 1'b0;
    end else if (step) begin
      rom_bank_r <= rom_bank_nxt;
      ram_bank_r <= ram_bank_nxt;
      mode_r     <= mode_nxt;
      ram_en_r   <= ram_en_nxt;
    end
  end

`ifndef SYNTHESIS
  a_rom_low_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    rom_bank_r[4:0] != 5'd0)
    else $error("rom bank low bits are zero");

  a_mbc_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp.region == REGION_MBC) |-> (cfg.cart_is_mbc1 && req.kind == KIND_WRITE && !a[15]))
    else $error("bank controller region without controller write");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !(step && mbc_wr) |=> $stable({rom_bank_r, ram_bank_r, mode_r, ram_en_r}))
    else $error("bank state changed without controller write");
`endif

endmodule

// ===== rtl/core/banked_memory_map_translator_top.sv =====
// banked memory map translator
// in_ch carries one bus access per transaction (kind, bus_address, write_data);
// out_ch returns one result per access (region, physical_offset, ram_enabled),
// in the order the accesses were taken.
// the apb-style cfg port sets cart_is_mbc1 (0x0), video_bank (0x4) and
// work_bank (0x8); write it only while no access is in flight.
// a transaction taken from in_ch moves through the input register and then
// the result register before its result shows on out_ch.
// throughput: one transaction per cycle while out_ch is not stalled, set by
// the single decode stage between the input register and the result register.
// when out_ch stalls, the result register holds and the input register still
// takes one more transaction; in_ch.ready drops once both are full.
// bank controller writes update the rom bank, cart ram bank, mode and ram
// enable state as the access moves into the result register.
// synchronous active-low reset empties both registers, sets the rom bank to 1,
// work_bank to 1 and clears the remaining bank controller and cfg state.
module banked_memory_map_translator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  bmmt_in_if.sink                        in_ch,
  bmmt_out_if.source                     out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [bmmt_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [bmmt_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic [bmmt_pkg::PDATA_W-1:0]   cfg_prdata,
  output logic                           cfg_pready
);
  import bmmt_pkg::*;

  bmmt_cfg_t cfg_r, cfg_nxt;
  logic      s1_valid_r, s1_valid_nxt;
  bmmt_req_t s1_req_r, s1_req_nxt;
  logic      out_valid_r, out_valid_nxt;
  bmmt_rsp_t out_rsp_r, out_rsp_nxt;
  bmmt_rsp_t rsp;
  bmmt_req_t in_req;
  logic      out_free;
  logic      s1_go;
  logic      in_acc;
  logic      cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_paddr)
        CFG_ADDR_MBC1:  cfg_nxt.cart_is_mbc1 = cfg_pwdata[0];
        CFG_ADDR_VBANK: cfg_nxt.video_bank   = cfg_pwdata[0];
        CFG_ADDR_WBANK: cfg_nxt.work_bank    = cfg_pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      CFG_ADDR_MBC1:  cfg_prdata = {31'd0, cfg_r.cart_is_mbc1};
      CFG_ADDR_VBANK: cfg_prdata = {31'd0, cfg_r.video_bank};
      CFG_ADDR_WBANK: cfg_prdata = {29'd0, cfg_r.work_bank};
      default:        cfg_prdata = '0;
    endcase
  end

  // two-register pipeline
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_go       = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign in_req.kind        = in_ch.kind;
  assign in_req.bus_address = in_ch.bus_address;
  assign in_req.write_data  = in_ch.write_data;

  always_comb begin
    s1_valid_nxt  = in_acc || (s1_valid_r && !s1_go);
    s1_req_nxt    = in_acc ? in_req : s1_req_r;
    out_valid_nxt = s1_go || (out_valid_r && !out_ch.ready);
    out_rsp_nxt   = s1_go ? rsp : out_rsp_r;
  end

  bmmt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_go),
    .cfg   (cfg_r),
    .req   (s1_req_r),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cart_is_mbc1 <= 1'b0;
      cfg_r.video_bank   <= 1'b0;
      cfg_r.work_bank    <= 3'd1;
      s1_valid_r         <= 1'b0;
      out_valid_r        <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_req_r  <= s1_req_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.region          = out_rsp_r.region;
  assign out_ch.physical_offset = out_rsp_r.physical_offset;
  assign out_ch.ram_enabled     = out_rsp_r.ram_enabled;

`ifndef SYNTHESIS
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r))
    else $error("pipeline not empty after reset");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> out_valid_r)
    else $error("transaction lost between stages");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(s1_req_r)))
    else $error("stalled input stage changed");

  a_region_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_rsp_r.region <= REGION_MBC))
    else $error("region code out of range");
`endif

endmodule
